@@ rtl/assert_macros.svh @@
// Assertion macros shared by the responder RTL; they expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: condition does not hold");

// A condition that must hold at any edge where a trigger is seen.
`define ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: implication does not hold");

`endif

@@ rtl/ssr_pkg.sv @@
// Types, constants and the CRC-8 helper shared by the responder modules.
package ssr_pkg;

  localparam int RX_LIMIT  = 64;
  localparam int CNT_W     = $clog2(RX_LIMIT + 1);
  localparam int REQ_LEN   = 4;
  localparam int REQ_IDX_W = $clog2(REQ_LEN);
  localparam int Q_DEPTH   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] LEN_LED   = 8'h01;
  localparam logic [7:0] LEN_ERR   = 8'h03;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  localparam logic [7:0] RST_LED_CMD    = 8'd1;
  localparam logic [7:0] RST_ERR_CMD    = 8'd255;
  localparam logic [7:0] RST_UNSUP_CODE = 8'd1;

  typedef enum logic [1:0] {
    OP_CS_FALL = 2'd0,
    OP_BYTE    = 2'd1,
    OP_CS_RISE = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LED_CMD    = 2'd0,
    CFG_ERR_CMD    = 2'd1,
    CFG_UNSUP_CODE = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] led_cmd;
    logic [7:0] err_cmd;
    logic [7:0] unsup_code;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_START,
    CMD_END,
    CMD_BYTE
  } cmd_kind_t;

  // One classified event on its way from the front to the back.
  typedef struct packed {
    cmd_kind_t  kind;
    logic       eval;
    logic       ok;
    logic       value;
    logic [7:0] req0;
    logic [7:0] req3;
  } cmd_t;

  // Steps of the error-frame CRC, one byte per cycle after the head byte.
  typedef enum logic [2:0] {
    ECRC_IDLE,
    ECRC_LEN,
    ECRC_REQ0,
    ECRC_ZERO,
    ECRC_CODE
  } ecrc_state_t;

  // CRC-8, MSB first, over one more byte.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ rtl/ssr_if.sv @@
// Request and result channel interfaces of the responder.
interface ssr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;
  modport source(output valid, opcode, rx_byte, input ready);
  modport sink(input valid, opcode, rx_byte, output ready);
endinterface

interface ssr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       irq_active;
  logic       led_write;
  logic       led_value;
  modport source(output valid, tx_byte, irq_active, led_write, led_value, input ready);
  modport sink(input valid, tx_byte, irq_active, led_write, led_value, output ready);
endinterface

@@ rtl/ssr_front.sv @@
// Front end: accepts events, keeps the request bytes and checks the request.
`include "assert_macros.svh"

module ssr_front (
  input  logic           clk,
  input  logic           rst,
  ssr_in_if.sink         rx_chan,
  input  ssr_pkg::cfg_t  cfg,
  input  logic           q_full,
  output logic           push,
  output ssr_pkg::cmd_t  cmd
);

  logic [ssr_pkg::CNT_W-1:0] rx_count;
  logic [ssr_pkg::CNT_W-1:0] rx_count_next;
  logic [7:0]                req [ssr_pkg::REQ_LEN];
  logic [7:0]                eff [ssr_pkg::REQ_LEN];
  logic [7:0]                crc_acc;

  assign rx_chan.ready = !q_full;
  assign push          = rx_chan.valid && rx_chan.ready;

  assign rx_count_next = (rx_count < ssr_pkg::CNT_W'(ssr_pkg::RX_LIMIT)) ?
                         rx_count + ssr_pkg::CNT_W'(1) : rx_count;

  // The byte arriving now stands in for the entry it is about to fill.
  always_comb begin
    for (int i = 0; i < ssr_pkg::REQ_LEN; i++) begin
      eff[i] = (rx_count == ssr_pkg::CNT_W'(i)) ? rx_chan.rx_byte : req[i];
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.kind  = ssr_pkg::CMD_NOP;
    cmd.value = eff[2][0];
    cmd.req0  = eff[0];
    cmd.req3  = eff[3];
    case (rx_chan.opcode)
      ssr_pkg::OP_CS_FALL: begin
        cmd.kind = ssr_pkg::CMD_START;
      end
      ssr_pkg::OP_CS_RISE: begin
        cmd.kind = ssr_pkg::CMD_END;
      end
      ssr_pkg::OP_BYTE: begin
        cmd.kind = ssr_pkg::CMD_BYTE;
        cmd.eval = (rx_count_next == ssr_pkg::CNT_W'(ssr_pkg::REQ_LEN));
        cmd.ok   = (eff[0] == cfg.led_cmd) && (eff[1] == ssr_pkg::LEN_LED) &&
                   (eff[2][7:1] == 7'd0) && (crc_acc == eff[3]);
      end
      default: begin
        cmd.kind = ssr_pkg::CMD_NOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count <= '0;
      crc_acc  <= '0;
    end else if (push) begin
      case (rx_chan.opcode)
        ssr_pkg::OP_CS_FALL: begin
          rx_count <= '0;
          crc_acc  <= '0;
        end
        ssr_pkg::OP_BYTE: begin
          rx_count <= rx_count_next;
          // The running CRC covers only the first three request bytes.
          if (rx_count < ssr_pkg::CNT_W'(ssr_pkg::REQ_LEN - 1)) begin
            crc_acc <= ssr_pkg::crc8_step(crc_acc, rx_chan.rx_byte);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && rx_chan.opcode == ssr_pkg::OP_BYTE &&
        rx_count < ssr_pkg::CNT_W'(ssr_pkg::REQ_LEN)) begin
      req[rx_count[ssr_pkg::REQ_IDX_W-1:0]] <= rx_chan.rx_byte;
    end
  end

  `ASSERT_ALWAYS(a_count_saturates, rx_count <= ssr_pkg::CNT_W'(ssr_pkg::RX_LIMIT))

endmodule

@@ rtl/ssr_queue.sv @@
// Short command queue that decouples the front end from the back end.
`include "assert_macros.svh"

module ssr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ssr_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output ssr_pkg::cmd_t head
);

  localparam int PTR_W = (ssr_pkg::Q_DEPTH > 1) ? $clog2(ssr_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(ssr_pkg::Q_DEPTH + 1);

  ssr_pkg::cmd_t    mem [ssr_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(ssr_pkg::Q_DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(ssr_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(ssr_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `ASSERT_IMPL(a_no_overflow, push, !full)

endmodule

@@ rtl/ssr_back.sv @@
// Back end: builds responses, hands out response bytes and drives the results.
`include "assert_macros.svh"

module ssr_back (
  input  logic          clk,
  input  logic          rst,
  input  ssr_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  ssr_pkg::cmd_t cmd,
  output logic          pop,
  ssr_out_if.source     tx_chan
);

  localparam logic [2:0] ECHO_LEN = 3'd4;
  localparam logic [2:0] ERR_LEN  = 3'd6;
  localparam logic [2:0] CRC_POS  = 3'd5;

  logic                 resp_ready;
  logic [2:0]           resp_len;
  logic [2:0]           send_pos;
  logic                 irq;
  logic [7:0]           resp [5];
  logic [7:0]           err_crc;
  ssr_pkg::ecrc_state_t crc_step;
  ssr_pkg::ecrc_state_t crc_step_next;
  logic [7:0]           step_data;

  logic       out_valid;
  logic [7:0] out_tx;
  logic       out_irq;
  logic       out_lw;
  logic       out_lv;

  logic       out_free;
  logic       evaluate;
  logic       advance;
  logic [2:0] pos_inc;
  logic [7:0] pos_byte;
  logic [7:0] tx_calc;
  logic       irq_calc;
  logic       lw_calc;
  logic       lv_calc;

  assign out_free = !out_valid || tx_chan.ready;
  assign pop      = q_valid && out_free;

  assign evaluate = (cmd.kind == ssr_pkg::CMD_BYTE) && cmd.eval && !resp_ready;
  assign advance  = (cmd.kind == ssr_pkg::CMD_BYTE) && !evaluate && resp_ready &&
                    (resp_len != 3'd0);
  assign pos_inc  = (send_pos < resp_len) ? send_pos + 3'd1 : send_pos;

  always_comb begin
    case (pos_inc)
      3'd0:    pos_byte = resp[0];
      3'd1:    pos_byte = resp[1];
      3'd2:    pos_byte = resp[2];
      3'd3:    pos_byte = resp[3];
      3'd4:    pos_byte = resp[4];
      CRC_POS: pos_byte = err_crc;
      default: pos_byte = ssr_pkg::BYTE_ZERO;
    endcase
  end

  always_comb begin
    tx_calc  = ssr_pkg::BYTE_ZERO;
    irq_calc = irq;
    lw_calc  = 1'b0;
    lv_calc  = 1'b0;
    case (cmd.kind)
      ssr_pkg::CMD_START, ssr_pkg::CMD_END: begin
        irq_calc = 1'b0;
      end
      ssr_pkg::CMD_BYTE: begin
        if (evaluate) begin
          tx_calc  = cmd.ok ? cfg.led_cmd : cfg.err_cmd;
          irq_calc = 1'b1;
          lw_calc  = cmd.ok;
          lv_calc  = cmd.ok && cmd.value;
        end else if (advance) begin
          tx_calc = (pos_inc < resp_len) ? pos_byte : ssr_pkg::BYTE_ZERO;
        end
      end
      default: begin
      end
    endcase
  end

  // Session and response control.
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_ready <= 1'b0;
      resp_len   <= '0;
      send_pos   <= '0;
      irq        <= 1'b0;
    end else if (pop) begin
      irq <= irq_calc;
      case (cmd.kind)
        ssr_pkg::CMD_START, ssr_pkg::CMD_END: begin
          resp_ready <= 1'b0;
          resp_len   <= '0;
          send_pos   <= '0;
        end
        ssr_pkg::CMD_BYTE: begin
          if (evaluate) begin
            resp_ready <= 1'b1;
            resp_len   <= cmd.ok ? ECHO_LEN : ERR_LEN;
            send_pos   <= '0;
          end else if (advance) begin
            send_pos <= pos_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && evaluate) begin
      if (cmd.ok) begin
        resp[0] <= cfg.led_cmd;
        resp[1] <= ssr_pkg::LEN_LED;
        resp[2] <= {7'd0, cmd.value};
        // A valid request carries the CRC of the same three bytes.
        resp[3] <= cmd.req3;
      end else begin
        resp[0] <= cfg.err_cmd;
        resp[1] <= ssr_pkg::LEN_ERR;
        resp[2] <= cmd.req0;
        resp[3] <= ssr_pkg::BYTE_ZERO;
        resp[4] <= cfg.unsup_code;
      end
    end
  end

  // The error-frame CRC steps through the length, request, zero and code bytes once
  // the frame is built, and is done before the fifth later byte can ask for it.
  always_comb begin
    crc_step_next = crc_step;
    if (pop && evaluate && !cmd.ok) begin
      crc_step_next = ssr_pkg::ECRC_LEN;
    end else begin
      case (crc_step)
        ssr_pkg::ECRC_LEN:  crc_step_next = ssr_pkg::ECRC_REQ0;
        ssr_pkg::ECRC_REQ0: crc_step_next = ssr_pkg::ECRC_ZERO;
        ssr_pkg::ECRC_ZERO: crc_step_next = ssr_pkg::ECRC_CODE;
        ssr_pkg::ECRC_CODE: crc_step_next = ssr_pkg::ECRC_IDLE;
        default:            crc_step_next = crc_step;
      endcase
    end
  end

  always_comb begin
    case (crc_step)
      ssr_pkg::ECRC_LEN:  step_data = ssr_pkg::LEN_ERR;
      ssr_pkg::ECRC_REQ0: step_data = resp[2];
      ssr_pkg::ECRC_ZERO: step_data = ssr_pkg::BYTE_ZERO;
      ssr_pkg::ECRC_CODE: step_data = resp[4];
      default:            step_data = ssr_pkg::BYTE_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_step <= ssr_pkg::ECRC_IDLE;
    end else begin
      crc_step <= crc_step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && evaluate && !cmd.ok) begin
      err_crc <= ssr_pkg::crc8_step(ssr_pkg::BYTE_ZERO, cfg.err_cmd);
    end else if (crc_step != ssr_pkg::ECRC_IDLE) begin
      err_crc <= ssr_pkg::crc8_step(err_crc, step_data);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (tx_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_tx  <= tx_calc;
      out_irq <= irq_calc;
      out_lw  <= lw_calc;
      out_lv  <= lv_calc;
    end
  end

  assign tx_chan.valid      = out_valid;
  assign tx_chan.tx_byte    = out_tx;
  assign tx_chan.irq_active = out_irq;
  assign tx_chan.led_write  = out_lw;
  assign tx_chan.led_value  = out_lv;

  `ASSERT_ALWAYS(a_pos_within_len, send_pos <= resp_len)
  `ASSERT_ALWAYS(a_irq_tracks_ready, irq == resp_ready)
  `ASSERT_IMPL(a_ready_len, resp_ready, resp_len == ECHO_LEN || resp_len == ERR_LEN)

endmodule

@@ rtl/spi_slave_command_responder_top.sv @@
// Top level of the SPI slave command responder: configuration and the three parts.
//
//   channel   dir  handshake     payload
//   rx_chan   in   valid/ready   opcode, rx_byte
//   tx_chan   out  valid/ready   tx_byte, irq_active, led_write, led_value
//   cfg       in   cfg_we        cfg_index, cfg_data
//
// One event is accepted per clock while the queue is not full; each yields one
// result. The front registers the classified event into a two-entry queue, and
// the back turns the queue head into the result register.
// Reset (rst, synchronous) clears counters, flags and queue, and loads the
// configuration defaults. A stalled result holds the back, and a full queue
// drops rx_chan.ready.

module spi_slave_command_responder_top (
  input  logic                           clk,
  input  logic                           rst,
  ssr_in_if.sink                         rx_chan,
  ssr_out_if.source                      tx_chan,
  input  logic                           cfg_we,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data
);

  ssr_pkg::cfg_t cfg;
  ssr_pkg::cmd_t push_cmd;
  ssr_pkg::cmd_t head_cmd;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.led_cmd    <= ssr_pkg::RST_LED_CMD;
      cfg.err_cmd    <= ssr_pkg::RST_ERR_CMD;
      cfg.unsup_code <= ssr_pkg::RST_UNSUP_CODE;
    end else if (cfg_we) begin
      case (cfg_index)
        ssr_pkg::CFG_LED_CMD:    cfg.led_cmd    <= cfg_data;
        ssr_pkg::CFG_ERR_CMD:    cfg.err_cmd    <= cfg_data;
        ssr_pkg::CFG_UNSUP_CODE: cfg.unsup_code <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ssr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .rx_chan (rx_chan),
    .cfg     (cfg),
    .q_full  (q_full),
    .push    (push),
    .cmd     (push_cmd)
  );

  ssr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (head_cmd)
  );

  ssr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .cmd     (head_cmd),
    .pop     (pop),
    .tx_chan (tx_chan)
  );

endmodule

@@ tb/tb_spi_slave_command_responder_top.sv @@
// Self-checking testbench for the SPI slave command responder: a reply predictor and random traffic.
import ssr_pkg::*;

typedef struct packed {
  logic [7:0] tx_byte;
  logic       irq_active;
  logic       led_write;
  logic       led_value;
} spi_reply_t;

class spi_reply_tracker;
  cfg_t        regs;
  logic [7:0]  req_store[4];
  int unsigned rx_seen;
  logic [7:0]  reply_store[6];
  int unsigned reply_len;
  int unsigned reply_pos;
  bit          reply_armed;
  bit          in_session;
  bit          irq_level;
  spi_reply_t  replies_due[$];
  int unsigned failures;

  function new();
    regs.led_cmd    = RST_LED_CMD;
    regs.err_cmd    = RST_ERR_CMD;
    regs.unsup_code = RST_UNSUP_CODE;
    foreach (req_store[i]) req_store[i] = BYTE_ZERO;
    foreach (reply_store[i]) reply_store[i] = BYTE_ZERO;
    rx_seen     = 0;
    reply_len   = 0;
    reply_pos   = 0;
    reply_armed = 1'b0;
    in_session  = 1'b0;
    irq_level   = 1'b0;
    failures    = 0;
  endfunction

  function void set_reg(cfg_index_t idx, logic [7:0] value);
    case (idx)
      CFG_LED_CMD:    regs.led_cmd = value;
      CFG_ERR_CMD:    regs.err_cmd = value;
      CFG_UNSUP_CODE: regs.unsup_code = value;
      default: ;
    endcase
  endfunction

  // CRC-8 with polynomial 0x07, most significant bit first.
  function logic [7:0] crc_next(logic [7:0] crc, logic [7:0] data);
    logic [7:0] s;
    s = crc ^ data;
    repeat (8) s = s[7] ? ((s << 1) ^ CRC_POLY) : (s << 1);
    return s;
  endfunction

  function logic [7:0] led_crc(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    return crc_next(crc_next(crc_next(BYTE_ZERO, b0), b1), b2);
  endfunction

  function int unsigned pending();
    return replies_due.size();
  endfunction

  function void predict_reply(logic [1:0] op, logic [7:0] data);
    spi_reply_t r;
    logic [7:0] c;
    bit         ok;
    r = '0;
    if (op == OP_CS_FALL || op == OP_CS_RISE) begin
      if (op == OP_CS_FALL) rx_seen = 0;
      reply_len   = 0;
      reply_pos   = 0;
      reply_armed = 1'b0;
      in_session  = (op == OP_CS_FALL);
      irq_level   = 1'b0;
    end else if (op == OP_BYTE) begin
      if (rx_seen < REQ_LEN) req_store[rx_seen] = data;
      if (rx_seen < RX_LIMIT) rx_seen++;
      if (rx_seen == REQ_LEN && !reply_armed) begin
        ok = req_store[0] == regs.led_cmd && req_store[1] == LEN_LED &&
             (req_store[2] == BYTE_ZERO || req_store[2] == LEN_LED) &&
             led_crc(req_store[0], req_store[1], req_store[2]) == req_store[3];
        if (ok) begin
          r.led_write    = 1'b1;
          r.led_value    = req_store[2][0];
          reply_store[0] = regs.led_cmd;
          reply_store[1] = LEN_LED;
          reply_store[2] = {7'd0, req_store[2][0]};
          reply_store[3] = led_crc(reply_store[0], reply_store[1], reply_store[2]);
          reply_len      = 4;
        end else begin
          reply_store[0] = regs.err_cmd;
          reply_store[1] = LEN_ERR;
          reply_store[2] = req_store[0];
          reply_store[3] = BYTE_ZERO;
          reply_store[4] = regs.unsup_code;
          c = BYTE_ZERO;
          for (int k = 0; k < 5; k++) c = crc_next(c, reply_store[k]);
          reply_store[5] = c;
          reply_len      = 6;
        end
        reply_pos   = 0;
        reply_armed = 1'b1;
        r.tx_byte   = reply_store[0];
        irq_level   = 1'b1;
      end else if (reply_armed && reply_len > 0) begin
        // The send position stops at the end of the response; zeros follow.
        if (reply_pos < reply_len) reply_pos++;
        if (reply_pos < reply_len) r.tx_byte = reply_store[reply_pos];
      end
    end
    r.irq_active = irq_level;
    replies_due.push_back(r);
  endfunction

  function void match_reply(spi_reply_t got, time stamp);
    spi_reply_t want;
    if (replies_due.size() == 0) begin
      $display("%0t: result with no request pending: tx_byte %02h irq %0b led_write %0b led_value %0b",
               stamp, got.tx_byte, got.irq_active, got.led_write, got.led_value);
      failures++;
      return;
    end
    want = replies_due.pop_front();
    if (got !== want) begin
      $display("%0t: mismatch, expected tx_byte %02h irq %0b led_write %0b led_value %0b, actual tx_byte %02h irq %0b led_write %0b led_value %0b",
               stamp, want.tx_byte, want.irq_active, want.led_write, want.led_value,
               got.tx_byte, got.irq_active, got.led_write, got.led_value);
      failures++;
    end
  endfunction
endclass

module tb_spi_slave_command_responder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  OP_IGNORED    = 2'd3;
  localparam int unsigned RANDOM_ITEMS  = 550;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  ssr_in_if  rx_chan_if();
  ssr_out_if tx_chan_if();

  spi_reply_tracker replies;
  bit               steady = 1'b0;
  bit               hold_request = 1'b0;
  int unsigned      counted_items = 0;
  int unsigned      cycles = 0;

  spi_slave_command_responder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .rx_chan   (rx_chan_if),
    .tx_chan   (tx_chan_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timed out", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && tx_chan_if.valid && tx_chan_if.ready)
      replies.match_reply({tx_chan_if.tx_byte, tx_chan_if.irq_active,
                           tx_chan_if.led_write, tx_chan_if.led_value}, $time);
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    tx_chan_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        tx_chan_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        tx_chan_if.ready <= steady || ($urandom_range(99) >= 37);
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] data);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 37) begin
      rx_chan_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_chan_if.valid   <= 1'b1;
    rx_chan_if.opcode  <= op;
    rx_chan_if.rx_byte <= data;
    do @(posedge clk); while (!rx_chan_if.ready);
    replies.predict_reply(op, data);
    if (op != OP_IGNORED) counted_items++;
  endtask

  task automatic send_request(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3);
    send_item(OP_BYTE, b0);
    send_item(OP_BYTE, b1);
    send_item(OP_BYTE, b2);
    send_item(OP_BYTE, b3);
  endtask

  task automatic drain_replies();
    @(negedge clk);
    rx_chan_if.valid <= 1'b0;
    while (replies.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    replies.set_reg(idx, value);
  endtask

  // One chip-select session: mostly a well-formed LED request, sometimes broken.
  task automatic run_session();
    logic [7:0]  req[4];
    logic        value;
    int unsigned cut;
    int unsigned extra;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(6, 1)) send_item(2'($urandom_range(3)), rand_byte());
      return;
    end
    value  = 1'($urandom_range(1));
    req[0] = replies.regs.led_cmd;
    req[1] = LEN_LED;
    req[2] = {7'd0, value};
    req[3] = replies.led_crc(req[0], req[1], req[2]);
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(4))
        0: req[0] = rand_byte();
        1: req[1] = rand_byte();
        2: req[2] = rand_byte();
        3: req[3] ^= 8'($urandom_range(255, 1));
        default: foreach (req[i]) req[i] = rand_byte();
      endcase
    end
    if ($urandom_range(99) < 85) send_item(OP_CS_FALL, rand_byte());
    // A chip-select rise in the middle keeps the receive count.
    cut = ($urandom_range(99) < 8) ? $urandom_range(3) : 4;
    for (int i = 0; i < 4; i++) begin
      if (i == cut) send_item(OP_CS_RISE, rand_byte());
      send_item(OP_BYTE, req[i]);
    end
    // Now and then run the receive count into its limit.
    extra = ($urandom_range(99) < 5) ? $urandom_range(70, 60) : $urandom_range(7);
    repeat (extra) begin
      if ($urandom_range(99) < 4) send_item(OP_IGNORED, rand_byte());
      send_item(OP_BYTE, rand_byte());
    end
    if ($urandom_range(99) < 80) send_item(OP_CS_RISE, rand_byte());
  endtask

  initial begin
    logic [7:0]  setting[3];
    int unsigned target;
    bit          pressed;
    replies            = new();
    rx_chan_if.valid   = 1'b0;
    rx_chan_if.opcode  = OP_CS_FALL;
    rx_chan_if.rx_byte = 8'h00;
    cfg_we             = 1'b0;
    cfg_index          = CFG_LED_CMD;
    cfg_data           = 8'h00;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(OP_CS_RISE, 8'h00);
    send_item(OP_IGNORED, 8'hFF);
    // A request with no chip-select fall before it is still answered.
    send_request(RST_LED_CMD, LEN_LED, 8'h01, replies.led_crc(RST_LED_CMD, LEN_LED, 8'h01));
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_CS_FALL, 8'hFF);
    send_request(RST_LED_CMD, LEN_LED, BYTE_ZERO, replies.led_crc(RST_LED_CMD, LEN_LED, BYTE_ZERO));
    send_item(OP_IGNORED, 8'h00);
    // Three echo bytes remain; the fourth read finds the response used up.
    repeat (4) send_item(OP_BYTE, 8'hA5);
    send_item(OP_CS_FALL, 8'h00);
    send_request(8'hFF, 8'h00, 8'h02, 8'h00);
    repeat (2) send_item(OP_BYTE, 8'h5A);
    send_item(OP_CS_RISE, 8'hFF);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        drain_replies();
        case (phase)
          1: setting = '{8'h00, 8'h00, 8'h00};
          2: setting = '{8'hFF, 8'hFF, 8'hFF};
          default: setting = '{rand_byte(), rand_byte(), rand_byte()};
        endcase
        write_reg(CFG_LED_CMD, setting[0]);
        write_reg(CFG_ERR_CMD, setting[1]);
        write_reg(CFG_UNSUP_CODE, setting[2]);
      end
      steady  = (phase == 1);
      pressed = 1'b0;
      target  = counted_items + RANDOM_ITEMS / PHASES;
      while (counted_items < target) begin
        if (!pressed && counted_items + RANDOM_ITEMS / PHASES / 2 >= target) begin
          pressed = 1'b1;
          if (phase == 2) hold_request = 1'b1;
          if (phase == 3) drain_replies();
        end
        run_session();
      end
    end

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (replies.failures == 0 && replies.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
